// File: sv/cque_pkg.sv
// Shared types, constants and helpers for the circular queue with unique enqueue.
package cque_pkg;

  // Queue depth and derived widths
  localparam int unsigned CAPACITY = 8;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Byte held by an empty slot ('#')
  localparam logic [7:0] EMPTY_MARK = 8'd35;

  // Stream data widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 24;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_ENQ      = 2'd0,
    OP_ENQ_UNIQ = 2'd1,
    OP_DEQ      = 2'd2,
    OP_COUNT    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DUP   = 2'd3
  } st_e;

  // Slot store request from the sequencer
  typedef struct packed {
    logic       wr_en;   // store wdata at addr_w, mark slot occupied
    logic       clr_en;  // mark slot at addr_w empty
    idx_t       addr_w;
    logic [7:0] wdata;
    logic       rd_en;
    idx_t       rd_addr;
  } ram_req_t;

  // One finished result
  typedef struct packed {
    logic [3:0] fill_level;
    logic [3:0] match_count;
    st_e        status;
    logic [7:0] read_byte;
  } res_t;

  // Circular index increment
  function automatic idx_t idx_inc(input idx_t i);
    idx_t r;
    if (i == idx_t'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

// File: sv/cque_slot_ram.sv
// Slot store: byte memory with per-slot occupied bits, one write and one registered read.
module cque_slot_ram
  import cque_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ram_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]          mem [CAPACITY];
  logic [CAPACITY-1:0] occ_q;
  logic [7:0]          rdata_q;
  logic                rocc_q;

  // Data array, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr_w] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  // Occupied bits and registered read flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      rocc_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        occ_q[req_i.addr_w] <= 1'b1;
      end else if (req_i.clr_en) begin
        occ_q[req_i.addr_w] <= 1'b0;
      end
      if (req_i.rd_en) begin
        rocc_q <= occ_q[req_i.rd_addr];
      end
    end
  end

  // A slot never written or since emptied reads as the marker
  assign rdata_o = rocc_q ? rdata_q : EMPTY_MARK;

endmodule

// File: sv/cque_ctrl.sv
// Sequencer: pointers, fill count and the shared byte compare walked over the slots.
module cque_ctrl
  import cque_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  op_e        in_op_i,
  input  logic [7:0] in_byte_i,
  output ram_req_t   ram_req_o,
  input  logic [7:0] ram_rdata_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_TALLY,
    S_DEQ_RD,
    S_DONE
  } state_e;

  state_e     state_q, state_d;
  op_e        op_q, op_d;
  logic [7:0] byte_q, byte_d;
  idx_t       head_q, head_d;
  idx_t       tail_q, tail_d;
  cnt_t       fill_q, fill_d;
  idx_t       walk_q, walk_d;
  cnt_t       acc_q, acc_d;
  logic       cmp_pend_q, cmp_pend_d;
  logic [7:0] rbyte_q, rbyte_d;
  st_e        st_q, st_d;
  cnt_t       mcnt_q, mcnt_d;

  logic       full;
  logic       empty;
  logic       eq;
  cnt_t       total;

  assign full  = (fill_q == cnt_t'(CAPACITY));
  assign empty = (fill_q == '0);

  // Shared compare unit: last read slot against the latched byte
  assign eq    = (ram_rdata_i == byte_q);
  assign total = acc_q + cnt_t'(eq);

  // Next-state logic
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    byte_d     = byte_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    walk_d     = walk_q;
    acc_d      = acc_q;
    cmp_pend_d = (state_q == S_WALK);
    rbyte_d    = rbyte_q;
    st_d       = st_q;
    mcnt_d     = mcnt_q;
    ram_req_o  = '0;

    if (cmp_pend_q && eq) begin
      acc_d = acc_q + 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_op_i;
          byte_d  = in_byte_i;
          walk_d  = '0;
          acc_d   = '0;
          rbyte_d = '0;
          mcnt_d  = '0;
          st_d    = ST_OK;
          state_d = S_DONE;
          case (in_op_i)
            OP_ENQ: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                ram_req_o.wr_en  = 1'b1;
                ram_req_o.addr_w = tail_q;
                ram_req_o.wdata  = in_byte_i;
                tail_d           = idx_inc(tail_q);
                fill_d           = fill_q + 1'b1;
              end
            end
            OP_ENQ_UNIQ: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                state_d = S_WALK;
              end
            end
            OP_DEQ: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                // Read the head and free its slot in the same cycle
                ram_req_o.rd_en   = 1'b1;
                ram_req_o.rd_addr = head_q;
                ram_req_o.clr_en  = 1'b1;
                ram_req_o.addr_w  = head_q;
                fill_d            = fill_q - 1'b1;
                if (fill_q == cnt_t'(1)) begin
                  head_d = '0;
                  tail_d = '0;
                end else begin
                  head_d = idx_inc(head_q);
                end
                state_d = S_DEQ_RD;
              end
            end
            OP_COUNT: begin
              state_d = S_WALK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // One slot read per cycle, compared in the cycle after its read
      S_WALK: begin
        ram_req_o.rd_en   = 1'b1;
        ram_req_o.rd_addr = walk_q;
        if (walk_q == idx_t'(CAPACITY - 1)) begin
          state_d = S_TALLY;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end

      // Last compare lands here; decide count or unique enqueue
      S_TALLY: begin
        state_d = S_DONE;
        if (op_q == OP_COUNT) begin
          mcnt_d = total;
        end else if (total != '0) begin
          st_d = ST_DUP;
        end else begin
          ram_req_o.wr_en  = 1'b1;
          ram_req_o.addr_w = tail_q;
          ram_req_o.wdata  = byte_q;
          tail_d           = idx_inc(tail_q);
          fill_d           = fill_q + 1'b1;
        end
      end

      S_DEQ_RD: begin
        rbyte_d = ram_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_ENQ;
      byte_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      walk_q     <= '0;
      acc_q      <= '0;
      cmp_pend_q <= 1'b0;
      rbyte_q    <= '0;
      st_q       <= ST_OK;
      mcnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      byte_q     <= byte_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      walk_q     <= walk_d;
      acc_q      <= acc_d;
      cmp_pend_q <= cmp_pend_d;
      rbyte_q    <= rbyte_d;
      st_q       <= st_d;
      mcnt_q     <= mcnt_d;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.read_byte   = rbyte_q;
  assign res_o.status      = st_q;
  assign res_o.match_count = 4'(mcnt_q);
  assign res_o.fill_level  = 4'(fill_q);

endmodule

// File: sv/circular_queue_unique_enqueue_core.sv
// Top level: circular byte queue with unique enqueue, stream ports and output register.
// Per item: enqueue, or a refusal on a full or empty queue, goes straight to the result;
// a dequeue reads the head slot first; count and enqueue-if-absent walk every slot, then tally.
// No new item is taken until its result is handed to the output register. The count walk reads
// one slot a cycle through the single slot-store read port and one byte comparator.
// Reset (rst_ni low, asynchronous): queue empty, every slot reads as '#', no result held.
module circular_queue_unique_enqueue_core
  import cque_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [1:0] operation, [9:2] data_byte, [15:10] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] read_byte, [9:8] status, [13:10] match_count, [17:14] fill_level, [23:18] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  ram_req_t             ram_req;
  logic [7:0]           ram_rdata;
  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;
  logic                 out_vld_q;
  logic [M_TDATA_W-1:0] out_data_q;

  cque_slot_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  cque_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tdata[1:0])),
    .in_byte_i   (s_axis_tdata[9:2]),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register frees the sequencer once a result is handed over
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (res_valid && res_ready) begin
        out_vld_q  <= 1'b1;
        out_data_q <= {6'b0, res.fill_level, res.match_count, res.status, res.read_byte};
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/cque_checker.sv
// Port-level checker for the circular queue core, bound to the top level.
module cque_checker
  import cque_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // A held result stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item at a time: busy in the cycle after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // Refused dequeue reports an empty queue and no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[9:8] == ST_EMPTY) |->
      (m_axis_tdata[17:14] == 4'd0) && (m_axis_tdata[7:0] == 8'd0))
    else $error("empty status with entries or data");

  // Refused enqueue only on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[9:8] == ST_FULL) |->
      (m_axis_tdata[17:14] == 4'(CAPACITY)))
    else $error("full status below capacity");

  // Fill level never above capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:14] <= 4'(CAPACITY)))
    else $error("fill level above capacity");

endmodule

bind circular_queue_unique_enqueue_core cque_checker u_cque_checker (.*);

// File: tb/sv/tb.sv
// Self-checking stream testbench for the circular byte queue with unique enqueue.
`timescale 1ns / 1ps

module tb
  import cque_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PER_PHASE = 600;

  // One expected result, fields as they leave the block
  typedef struct {
    logic [7:0] read_byte;
    st_e        status;
    logic [3:0] match_count;
    logic [3:0] fill_level;
  } reply_t;

  // Scoreboard: mirrors the queue and holds replies still owed by the block
  class dedup_queue_scoreboard;
    logic [7:0]  slot_q [CAPACITY];
    int unsigned head_pos;
    int unsigned tail_pos;
    reply_t      owed_replies[$];
    int unsigned mismatches;

    function new();
      foreach (slot_q[i]) slot_q[i] = EMPTY_MARK;
      head_pos   = 0;
      tail_pos   = 0;
      mismatches = 0;
    endfunction

    function int unsigned fill_now();
      if (head_pos == 0 && tail_pos == 0) return 0;
      if (head_pos <= tail_pos) return tail_pos - head_pos + 1;
      return CAPACITY - head_pos + tail_pos + 1;
    endfunction

    // Empty slots hold the marker, so they match it too
    function int unsigned slots_equal(input logic [7:0] value);
      int unsigned n;
      n = 0;
      foreach (slot_q[i]) if (slot_q[i] == value) n++;
      return n;
    endfunction

    function void push_byte(input logic [7:0] value);
      if (head_pos == 0 && tail_pos == 0) begin
        head_pos = 1;
      end else if (tail_pos >= CAPACITY) begin
        tail_pos = 0;
      end
      tail_pos++;
      slot_q[(tail_pos - 1) % CAPACITY] = value;
    endfunction

    // Work out the reply for an accepted transfer and queue it
    function void note_request(input op_e op, input logic [7:0] value);
      reply_t      r;
      logic        is_full;
      int unsigned idx;
      r.read_byte   = '0;
      r.status      = ST_OK;
      r.match_count = '0;
      is_full       = fill_now() >= CAPACITY;
      case (op)
        OP_ENQ: begin
          if (is_full) r.status = ST_FULL;
          else push_byte(value);
        end
        OP_ENQ_UNIQ: begin
          if (is_full) r.status = ST_FULL;
          else if (slots_equal(value) != 0) r.status = ST_DUP;
          else push_byte(value);
        end
        OP_DEQ: begin
          if (head_pos == 0 && tail_pos == 0) begin
            r.status = ST_EMPTY;
          end else begin
            idx         = (head_pos - 1) % CAPACITY;
            r.read_byte = slot_q[idx];
            slot_q[idx] = EMPTY_MARK;
            if (head_pos == tail_pos) begin
              head_pos = 0;
              tail_pos = 0;
            end else if (head_pos >= CAPACITY) begin
              head_pos = 1;
            end else begin
              head_pos++;
            end
          end
        end
        default: r.match_count = 4'(slots_equal(value));
      endcase
      r.fill_level = 4'(fill_now());
      owed_replies.push_back(r);
    endfunction

    function void report(input string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, what);
    endfunction

    // Compare one result transfer with the oldest owed reply
    function void check_reply(input logic [M_TDATA_W-1:0] data);
      reply_t want;
      reply_t got;
      got.read_byte   = data[7:0];
      got.status      = st_e'(data[9:8]);
      got.match_count = data[13:10];
      got.fill_level  = data[17:14];
      if (owed_replies.size() == 0) begin
        report($sformatf("result with none owed: rd=%0d st=%0d cnt=%0d lvl=%0d",
                         got.read_byte, got.status, got.match_count, got.fill_level));
        return;
      end
      want = owed_replies.pop_front();
      if (got.read_byte != want.read_byte || got.status != want.status ||
          got.match_count != want.match_count || got.fill_level != want.fill_level ||
          data[M_TDATA_W-1:18] != '0) begin
        report($sformatf("exp rd=%0d st=%0d cnt=%0d lvl=%0d, got rd=%0d st=%0d cnt=%0d lvl=%0d pad=%0h",
                         want.read_byte, want.status, want.match_count, want.fill_level,
                         got.read_byte, got.status, got.match_count, got.fill_level,
                         data[M_TDATA_W-1:18]));
      end
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  dedup_queue_scoreboard sb;
  int unsigned send_gap_pct;
  int unsigned recv_idle_pct;
  bit          rx_hold_request;
  int unsigned cycle_count;

  circular_queue_unique_enqueue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("circular_queue_unique_enqueue_core: mismatch");
        $finish;
      end
    end
  end

  // Result side: check each transfer, stall at random or for one long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        hold_left = RX_HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item, with a random gap first, and wait for its transfer
  task automatic send_op(input op_e op, input logic [7:0] value);
    if ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({value, op});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, value);
  endtask

  // Random items in stretches that fill, drain or mix the queue
  task automatic run_random(input int unsigned n);
    int unsigned mode;
    int unsigned r;
    op_e         op;
    logic [7:0]  value;
    mode = 0;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 24 == 0) mode = $urandom_range(2);
      r = $urandom_range(99);
      case (mode)
        0:       op = (r < 35) ? OP_ENQ : (r < 70) ? OP_ENQ_UNIQ : (r < 85) ? OP_DEQ : OP_COUNT;
        1:       op = (r < 15) ? OP_ENQ : (r < 30) ? OP_ENQ_UNIQ : (r < 80) ? OP_DEQ : OP_COUNT;
        default: op = op_e'(r % 4);
      endcase
      // A small pool of bytes makes duplicates and counts likely
      r = $urandom_range(99);
      if (r < 40) value = 8'($urandom_range(7));
      else if (r < 50) value = EMPTY_MARK;
      else value = 8'($urandom_range(255));
      send_op(op, value);
    end
  endtask

  // Stimulus
  initial begin
    sb = new();
    rx_hold_request = 1'b0;
    send_gap_pct    = 12;
    recv_idle_pct   = 54;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty refusals, marker handling, duplicates, full queue, drain to empty
    send_op(OP_DEQ, 8'd0);
    send_op(OP_COUNT, EMPTY_MARK);
    send_op(OP_ENQ_UNIQ, EMPTY_MARK);
    send_op(OP_ENQ, 8'd0);
    send_op(OP_ENQ, 8'd255);
    send_op(OP_ENQ, EMPTY_MARK);
    send_op(OP_ENQ_UNIQ, 8'd0);
    send_op(OP_ENQ_UNIQ, 8'd7);
    send_op(OP_COUNT, EMPTY_MARK);
    for (int unsigned i = 1; i <= 4; i++) send_op(OP_ENQ, 8'(i));
    send_op(OP_ENQ, 8'd9);
    send_op(OP_ENQ_UNIQ, 8'd200);
    for (int unsigned i = 0; i < CAPACITY; i++) send_op(OP_DEQ, 8'hff);
    send_op(OP_DEQ, 8'd0);

    run_random(RANDOM_PER_PHASE);
    send_gap_pct  = 54;
    recv_idle_pct = 12;
    run_random(RANDOM_PER_PHASE);
    send_gap_pct  = 0;
    recv_idle_pct = 0;
    // Long receiver hold-off while items keep coming, so the input backs up
    rx_hold_request = 1'b1;
    run_random(RANDOM_PER_PHASE);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("circular_queue_unique_enqueue_core: match");
    end else begin
      $display("circular_queue_unique_enqueue_core: mismatch");
    end
    $finish;
  end

endmodule
